// File: src/upng_pkg.sv
// Package for the uncompressed PNG stream encoder: constants, sequencer states, CRC step.
package upng_pkg;

    localparam int MaxSide = 16384;
    localparam logic [31:0] CrcPoly = 32'hEDB88320;
    localparam logic [31:0] AllOnes = 32'hFFFFFFFF;
    localparam logic [16:0] AdlerMod = 17'd65521;
    localparam logic [15:0] BlockMax = 16'd65535;
    localparam logic [7:0] CfgWidth = 8'd0;
    localparam logic [7:0] CfgHeight = 8'd1;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_SIZE,
        PH_RAWCNT,
        PH_BLKCNT,
        PH_LENCALC,
        PH_SIG,
        PH_IHLEN,
        PH_IHBODY,
        PH_IHCRC,
        PH_IDLEN,
        PH_IDTAG,
        PH_ZLIB,
        PH_BHDR,
        PH_RAW,
        PH_ADLER,
        PH_IDCRC,
        PH_IELEN,
        PH_IETAG,
        PH_IECRC
    } phase_t;

    // one byte through the reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            v = v[0] ? ((v >> 1) ^ CrcPoly) : (v >> 1);
        end
        return v;
    endfunction

    // PNG signature bytes
    function automatic logic [7:0] sig_byte(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0: r = 8'h89;
            3'd1: r = 8'h50;
            3'd2: r = 8'h4E;
            3'd3: r = 8'h47;
            3'd4: r = 8'h0D;
            3'd5: r = 8'h0A;
            3'd6: r = 8'h1A;
            default: r = 8'h0A;
        endcase
        return r;
    endfunction

    // big-endian byte of a word
    function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] i);
        logic [7:0] r;
        unique case (i)
            2'd0: r = w[31:24];
            2'd1: r = w[23:16];
            2'd2: r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

endpackage

// File: src/uncompressed_png_stream_encoder.sv
// Top level: byte-serial PNG encoder with shared CRC unit, Adler-32 and word packer.
//
//  channel | signals                        | word
//  --------+--------------------------------+------------------------------------
//  pixel   | s_tvalid s_tready s_tdata      | red, green, blue
//  file    | m_tvalid m_tready m_tdata      | out_data, byte_count; tlast run_last,
//          | m_tlast m_tuser                | tuser frame_end
//  config  | cfg_valid cfg_ready cfg_index  | register index, write data
//          | cfg_data                       |
//
// One byte is packed per cycle unless a stalled output word holds it. Chunk type and data
// bytes pass the shared byte-wise CRC unit. A pixel adds 3 or 4 raw bytes plus 5 per stored
// block header it opens. The first pixel of a frame runs the SIZE, RAWCNT, BLKCNT and
// LENCALC setup states and adds 43 header bytes, the last 20 bytes. s_tready is high only
// while the sequencer is idle. A stalled output word holds the sequencer at the byte that
// would complete the next word. Reset, asynchronous and active low, leaves both sizes at 1.
module uncompressed_png_stream_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_data[31:0], byte_count[34:32], zero[39:35]
    output logic        m_tlast,   // run_last
    output logic        m_tuser,   // frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    upng_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  idx_reg, idx_next;
    logic [1:0]  psel_reg, psel_next;
    logic [23:0] pix_reg, pix_next;
    logic [14:0] img_w_reg, img_h_reg;
    logic [14:0] fw_reg, fw_next, fh_reg, fh_next;
    logic [29:0] raw_reg, raw_next;
    logic [13:0] blocks_reg, blocks_next;
    logic [31:0] idat_len_reg, idat_len_next;
    logic [29:0] left_reg, left_next;
    logic [15:0] fill_reg, fill_next;
    logic [13:0] col_reg, col_next;
    logic [15:0] alow_reg, alow_next, ahigh_reg, ahigh_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  acnt_reg, acnt_next;
    logic        ov_reg, ov_next;
    logic [31:0] od_reg, od_next;
    logic [2:0]  oc_reg, oc_next;
    logic        ol_reg, ol_next, of_reg, of_next;

    logic [7:0]  byte_val;
    logic        push, crc_en, last_byte, fend, step_ok, out_free, at_end;
    logic [4:0]  last_idx;
    logic [16:0] low_sum, high_sum;
    logic [15:0] blen;
    logic [31:0] t_sum, q_sum;
    logic [16:0] tri_w;
    logic [31:0] shifted;

    assign s_tready  = (phase_reg == upng_pkg::PH_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ov_reg;
    assign m_tdata   = {5'd0, oc_reg, od_reg};
    assign m_tlast   = ol_reg;
    assign m_tuser   = of_reg;
    assign out_free  = !ov_reg || m_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= 15'd1;
            img_h_reg <= 15'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == upng_pkg::CfgWidth)
            begin
                img_w_reg <= cfg_data;
            end
            else if (cfg_index == upng_pkg::CfgHeight)
            begin
                img_h_reg <= cfg_data;
            end
        end
    end

    // stored block length field from bytes still to come
    assign blen   = (left_reg > 30'(upng_pkg::BlockMax)) ? upng_pkg::BlockMax : left_reg[15:0];
    assign at_end = (idx_reg == last_idx);
    // ceil(raw / 65535) via the reciprocal trick
    assign t_sum  = {2'd0, raw_reg} + 32'd65534;
    assign q_sum  = t_sum + 32'd1 + (t_sum >> 16);
    assign tri_w  = {2'd0, fw_reg} + {1'b0, fw_reg, 1'b0} + 17'd1;
    assign low_sum  = {1'b0, alow_reg} + {9'd0, byte_val};

    // bytes per phase, less one
    always_comb
    begin
        unique case (phase_reg)
            upng_pkg::PH_SIG:    last_idx = 5'd7;
            upng_pkg::PH_IHBODY: last_idx = 5'd16;
            upng_pkg::PH_ZLIB:   last_idx = 5'd1;
            upng_pkg::PH_BHDR:   last_idx = 5'd4;
            upng_pkg::PH_IHLEN, upng_pkg::PH_IHCRC, upng_pkg::PH_IDLEN, upng_pkg::PH_IDTAG,
            upng_pkg::PH_ADLER, upng_pkg::PH_IDCRC, upng_pkg::PH_IELEN, upng_pkg::PH_IETAG,
            upng_pkg::PH_IECRC:  last_idx = 5'd3;
            default:             last_idx = 5'd0;
        endcase
    end

    // byte source for the current step
    always_comb
    begin
        byte_val = 8'd0;
        push     = 1'b1;
        crc_en   = 1'b1;
        unique case (phase_reg)
            upng_pkg::PH_SIG:
            begin
                byte_val = upng_pkg::sig_byte(idx_reg[2:0]);
                crc_en   = 1'b0;
            end
            upng_pkg::PH_IHLEN:
            begin
                byte_val = upng_pkg::be_byte(32'd13, idx_reg[1:0]);
                crc_en   = 1'b0;
            end
            upng_pkg::PH_IHBODY:
            begin
                priority if (idx_reg < 5'd4)
                    byte_val = upng_pkg::be_byte(32'h49484452, idx_reg[1:0]);
                else if (idx_reg < 5'd8)
                    byte_val = upng_pkg::be_byte({17'd0, fw_reg}, idx_reg[1:0]);
                else if (idx_reg < 5'd12)
                    byte_val = upng_pkg::be_byte({17'd0, fh_reg}, idx_reg[1:0]);
                else if (idx_reg == 5'd12)
                    byte_val = 8'd8;
                else if (idx_reg == 5'd13)
                    byte_val = 8'd2;
                else
                    byte_val = 8'd0;
            end
            upng_pkg::PH_IHCRC, upng_pkg::PH_IDCRC, upng_pkg::PH_IECRC:
            begin
                byte_val = upng_pkg::be_byte(crc_reg ^ upng_pkg::AllOnes, idx_reg[1:0]);
                crc_en   = 1'b0;
            end
            upng_pkg::PH_IDLEN:
            begin
                byte_val = upng_pkg::be_byte(idat_len_reg, idx_reg[1:0]);
                crc_en   = 1'b0;
            end
            upng_pkg::PH_IDTAG:
                byte_val = upng_pkg::be_byte(32'h49444154, idx_reg[1:0]);
            upng_pkg::PH_ZLIB:
                byte_val = (idx_reg == 5'd0) ? 8'h78 : 8'h01;
            upng_pkg::PH_BHDR:
            begin
                unique case (idx_reg[2:0])
                    3'd0:    byte_val = (left_reg <= 30'(upng_pkg::BlockMax)) ? 8'd1 : 8'd0;
                    3'd1:    byte_val = blen[7:0];
                    3'd2:    byte_val = blen[15:8];
                    3'd3:    byte_val = ~blen[7:0];
                    default: byte_val = ~blen[15:8];
                endcase
            end
            upng_pkg::PH_RAW:
            begin
                unique case (psel_reg)
                    2'd0:    byte_val = 8'd0;
                    2'd1:    byte_val = pix_reg[7:0];
                    2'd2:    byte_val = pix_reg[15:8];
                    default: byte_val = pix_reg[23:16];
                endcase
            end
            upng_pkg::PH_ADLER:
                byte_val = upng_pkg::be_byte({ahigh_reg, alow_reg}, idx_reg[1:0]);
            upng_pkg::PH_IELEN:
            begin
                byte_val = 8'd0;
                crc_en   = 1'b0;
            end
            upng_pkg::PH_IETAG:
                byte_val = upng_pkg::be_byte(32'h49454E44, idx_reg[1:0]);
            default:
            begin
                push   = 1'b0;
                crc_en = 1'b0;
            end
        endcase
    end

    assign last_byte = ((phase_reg == upng_pkg::PH_RAW) && (psel_reg == 2'd3)
                        && (left_reg != 30'd1))
                       || ((phase_reg == upng_pkg::PH_IECRC) && at_end);
    assign fend      = (phase_reg == upng_pkg::PH_IECRC);
    assign step_ok   = !push || !((acnt_reg == 2'd3) || last_byte) || out_free;

    // sequencer, running sums and packer
    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        psel_next     = psel_reg;
        pix_next      = pix_reg;
        fw_next       = fw_reg;
        fh_next       = fh_reg;
        raw_next      = raw_reg;
        blocks_next   = blocks_reg;
        idat_len_next = idat_len_reg;
        left_next     = left_reg;
        fill_next     = fill_reg;
        col_next      = col_reg;
        alow_next     = alow_reg;
        ahigh_next    = ahigh_reg;
        crc_next      = crc_reg;
        acc_next      = acc_reg;
        acnt_next     = acnt_reg;
        ov_next       = ov_reg && !m_tready;
        od_next       = od_reg;
        oc_next       = oc_reg;
        ol_next       = ol_reg;
        of_next       = of_reg;
        high_sum      = 17'd0;
        shifted       = 32'd0;

        unique case (phase_reg)
            upng_pkg::PH_IDLE:
            begin
                if (s_tvalid)
                begin
                    pix_next  = s_tdata;
                    psel_next = (col_reg == 14'd0) ? 2'd0 : 2'd1;
                    priority if (left_reg == 30'd0)
                        phase_next = upng_pkg::PH_SIZE;
                    else if (fill_reg == 16'd0)
                        phase_next = upng_pkg::PH_BHDR;
                    else
                        phase_next = upng_pkg::PH_RAW;
                end
            end
            upng_pkg::PH_SIZE:
            begin
                fw_next = (img_w_reg == 15'd0) ? 15'd1
                        : (img_w_reg > 15'(upng_pkg::MaxSide)) ? 15'(upng_pkg::MaxSide)
                        : img_w_reg;
                fh_next = (img_h_reg == 15'd0) ? 15'd1
                        : (img_h_reg > 15'(upng_pkg::MaxSide)) ? 15'(upng_pkg::MaxSide)
                        : img_h_reg;
                crc_next   = upng_pkg::AllOnes;
                phase_next = upng_pkg::PH_RAWCNT;
            end
            upng_pkg::PH_RAWCNT:
            begin
                raw_next   = {15'd0, fh_reg} * {13'd0, tri_w};
                phase_next = upng_pkg::PH_BLKCNT;
            end
            upng_pkg::PH_BLKCNT:
            begin
                blocks_next = q_sum[29:16];
                phase_next  = upng_pkg::PH_LENCALC;
            end
            upng_pkg::PH_LENCALC:
            begin
                idat_len_next = {2'd0, raw_reg} + 32'd6 + {16'd0, blocks_reg, 2'd0}
                              + {18'd0, blocks_reg};
                left_next  = raw_reg;
                fill_next  = 16'd0;
                col_next   = 14'd0;
                alow_next  = 16'd1;
                ahigh_next = 16'd0;
                idx_next   = 5'd0;
                phase_next = upng_pkg::PH_SIG;
            end
            default:
            begin
                if (step_ok)
                begin
                    if (crc_en)
                    begin
                        crc_next = upng_pkg::crc_byte(crc_reg, byte_val);
                    end
                    // pack the byte
                    unique case (acnt_reg)
                        2'd0:    shifted = {byte_val, 24'd0};
                        2'd1:    shifted = {8'd0, byte_val, 16'd0};
                        2'd2:    shifted = {16'd0, byte_val, 8'd0};
                        default: shifted = {24'd0, byte_val};
                    endcase
                    if ((acnt_reg == 2'd3) || last_byte)
                    begin
                        ov_next   = 1'b1;
                        od_next   = acc_reg | shifted;
                        oc_next   = {1'b0, acnt_reg} + 3'd1;
                        ol_next   = last_byte;
                        of_next   = last_byte && fend;
                        acc_next  = 32'd0;
                        acnt_next = 2'd0;
                    end
                    else
                    begin
                        acc_next  = acc_reg | shifted;
                        acnt_next = acnt_reg + 2'd1;
                    end
                    idx_next = at_end ? 5'd0 : idx_reg + 5'd1;

                    unique case (phase_reg)
                        upng_pkg::PH_RAW:
                        begin
                            alow_next = (low_sum >= upng_pkg::AdlerMod)
                                      ? 16'(low_sum - upng_pkg::AdlerMod) : low_sum[15:0];
                            high_sum  = {1'b0, ahigh_reg} + {1'b0, alow_next};
                            ahigh_next = (high_sum >= upng_pkg::AdlerMod)
                                       ? 16'(high_sum - upng_pkg::AdlerMod) : high_sum[15:0];
                            left_next = left_reg - 30'd1;
                            fill_next = (fill_reg + 16'd1 >= upng_pkg::BlockMax)
                                      ? 16'd0 : fill_reg + 16'd1;
                            idx_next  = 5'd0;
                            if (psel_reg == 2'd3)
                            begin
                                col_next = ({1'b0, col_reg} + 15'd1 >= fw_reg)
                                         ? 14'd0 : col_reg + 14'd1;
                                phase_next = (left_next == 30'd0) ? upng_pkg::PH_ADLER
                                                                  : upng_pkg::PH_IDLE;
                            end
                            else
                            begin
                                psel_next  = psel_reg + 2'd1;
                                phase_next = (fill_next == 16'd0) ? upng_pkg::PH_BHDR
                                                                  : upng_pkg::PH_RAW;
                            end
                        end
                        default:
                        begin
                            if (at_end)
                            begin
                                unique case (phase_reg)
                                    upng_pkg::PH_SIG:    phase_next = upng_pkg::PH_IHLEN;
                                    upng_pkg::PH_IHLEN:  phase_next = upng_pkg::PH_IHBODY;
                                    upng_pkg::PH_IHBODY: phase_next = upng_pkg::PH_IHCRC;
                                    upng_pkg::PH_IHCRC:
                                    begin
                                        phase_next = upng_pkg::PH_IDLEN;
                                        crc_next   = upng_pkg::AllOnes;
                                    end
                                    upng_pkg::PH_IDLEN:  phase_next = upng_pkg::PH_IDTAG;
                                    upng_pkg::PH_IDTAG:  phase_next = upng_pkg::PH_ZLIB;
                                    upng_pkg::PH_ZLIB:
                                        phase_next = (fill_reg == 16'd0) ? upng_pkg::PH_BHDR
                                                                         : upng_pkg::PH_RAW;
                                    upng_pkg::PH_BHDR:   phase_next = upng_pkg::PH_RAW;
                                    upng_pkg::PH_ADLER:  phase_next = upng_pkg::PH_IDCRC;
                                    upng_pkg::PH_IDCRC:
                                    begin
                                        phase_next = upng_pkg::PH_IELEN;
                                        crc_next   = upng_pkg::AllOnes;
                                    end
                                    upng_pkg::PH_IELEN:  phase_next = upng_pkg::PH_IETAG;
                                    upng_pkg::PH_IETAG:  phase_next = upng_pkg::PH_IECRC;
                                    upng_pkg::PH_IECRC:
                                    begin
                                        phase_next = upng_pkg::PH_IDLE;
                                        crc_next   = upng_pkg::AllOnes;
                                        col_next   = 14'd0;
                                        fill_next  = 16'd0;
                                        alow_next  = 16'd1;
                                        ahigh_next = 16'd0;
                                    end
                                    default:             phase_next = upng_pkg::PH_IDLE;
                                endcase
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= upng_pkg::PH_IDLE;
            idx_reg      <= 5'd0;
            psel_reg     <= 2'd0;
            pix_reg      <= 24'd0;
            fw_reg       <= 15'd1;
            fh_reg       <= 15'd1;
            raw_reg      <= 30'd0;
            blocks_reg   <= 14'd0;
            idat_len_reg <= 32'd0;
            left_reg     <= 30'd0;
            fill_reg     <= 16'd0;
            col_reg      <= 14'd0;
            alow_reg     <= 16'd1;
            ahigh_reg    <= 16'd0;
            crc_reg      <= upng_pkg::AllOnes;
            acc_reg      <= 32'd0;
            acnt_reg     <= 2'd0;
            ov_reg       <= 1'b0;
            od_reg       <= 32'd0;
            oc_reg       <= 3'd0;
            ol_reg       <= 1'b0;
            of_reg       <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            psel_reg     <= psel_next;
            pix_reg      <= pix_next;
            fw_reg       <= fw_next;
            fh_reg       <= fh_next;
            raw_reg      <= raw_next;
            blocks_reg   <= blocks_next;
            idat_len_reg <= idat_len_next;
            left_reg     <= left_next;
            fill_reg     <= fill_next;
            col_reg      <= col_next;
            alow_reg     <= alow_next;
            ahigh_reg    <= ahigh_next;
            crc_reg      <= crc_next;
            acc_reg      <= acc_next;
            acnt_reg     <= acnt_next;
            ov_reg       <= ov_next;
            od_reg       <= od_next;
            oc_reg       <= oc_next;
            ol_reg       <= ol_next;
            of_reg       <= of_next;
        end
    end

endmodule

// File: src/upng_checker.sv
// Port-level checker for the PNG stream encoder, bound to the top level.
module upng_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // every word carries one to four bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[34:32] != 3'd0) && (m_tdata[34:32] <= 3'd4))
        else $error("byte count out of range");

    // file end only on the last word of a pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end without run end");

    // only the last word of a pixel may be short
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[34:32] == 3'd4))
        else $error("short word inside a run");

    // stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled word changed");

endmodule

bind uncompressed_png_stream_encoder upng_checker u_upng_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: tb/tb_uncompressed_png_stream_encoder.sv
// Testbench for the uncompressed PNG stream encoder: pixel stimulus, file word prediction, checks.
module tb_uncompressed_png_stream_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CfgSpare = 8'd2;
    localparam logic [7:0] CfgTop = 8'hFF;
    localparam int CycleLimit = 2000000;
    localparam int DrainCycles = 40;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
        logic        fend;
    } file_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [14:0] cfg_data;

    logic [23:0] pixel_queue[$];
    file_word_t  file_words_due[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          error_count;
    int          cycle_count;

    // encoder state as tracked by the predictor
    logic [14:0] size_w_reg, size_h_reg;
    int unsigned frm_w, frm_h, col_pos, blk_fill, raw_left, adl_lo, adl_hi;
    logic [31:0] idat_crc;
    logic [7:0]  pending_bytes[$];

    uncompressed_png_stream_encoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            v = v[0] ? ((v >> 1) ^ upng_pkg::CrcPoly) : (v >> 1);
        end
        return v;
    endfunction

    function automatic int unsigned clamp_side(input logic [14:0] v);
        if (v == 15'd0)
            return 1;
        if (v > upng_pkg::MaxSide)
            return upng_pkg::MaxSide;
        return v;
    endfunction

    task automatic emit_be32(input logic [31:0] v, inout logic [31:0] c);
        for (int s = 24; s >= 0; s -= 8)
        begin
            pending_bytes.push_back(v[s +: 8]);
            c = crc_step(c, v[s +: 8]);
        end
    endtask

    task automatic emit_idat(input logic [7:0] b);
        pending_bytes.push_back(b);
        idat_crc = crc_step(idat_crc, b);
    endtask

    // raw byte into the zlib stream, opening a stored block when one is due
    task automatic emit_raw(input logic [7:0] b);
        logic [15:0] len;
        if (blk_fill == 0)
        begin
            len = (raw_left > upng_pkg::BlockMax) ? upng_pkg::BlockMax : raw_left[15:0];
            emit_idat((raw_left <= upng_pkg::BlockMax) ? 8'd1 : 8'd0);
            emit_idat(len[7:0]);
            emit_idat(len[15:8]);
            emit_idat(~len[7:0]);
            emit_idat(~len[15:8]);
        end
        emit_idat(b);
        adl_lo = adl_lo + b;
        if (adl_lo >= upng_pkg::AdlerMod)
            adl_lo -= upng_pkg::AdlerMod;
        adl_hi = adl_hi + adl_lo;
        if (adl_hi >= upng_pkg::AdlerMod)
            adl_hi -= upng_pkg::AdlerMod;
        if (raw_left > 0)
            raw_left--;
        blk_fill++;
        if (blk_fill >= upng_pkg::BlockMax)
            blk_fill = 0;
    endtask

    // signature, IHDR, IDAT head and zlib header
    task automatic open_frame();
        logic [31:0] c, dummy;
        int unsigned raw, blocks;
        frm_w = clamp_side(size_w_reg);
        frm_h = clamp_side(size_h_reg);
        raw = frm_h * (1 + 3 * frm_w);
        blocks = (raw + upng_pkg::BlockMax - 1) / upng_pkg::BlockMax;
        c = upng_pkg::AllOnes;
        emit_be32(32'h89504E47, dummy);
        emit_be32(32'h0D0A1A0A, dummy);
        emit_be32(32'd13, dummy);
        emit_be32(32'h49484452, c);
        emit_be32(frm_w, c);
        emit_be32(frm_h, c);
        emit_be32(32'h08020000, c);
        pending_bytes.push_back(8'h00);
        c = crc_step(c, 8'h00);
        emit_be32(c ^ upng_pkg::AllOnes, dummy);
        emit_be32(2 + raw + 5 * blocks + 4, dummy);
        idat_crc = upng_pkg::AllOnes;
        emit_be32(32'h49444154, idat_crc);
        emit_idat(8'h78);
        emit_idat(8'h01);
        raw_left = raw;
        blk_fill = 0;
        col_pos = 0;
        adl_lo = 1;
        adl_hi = 0;
    endtask

    // Adler-32, IDAT CRC and IEND
    task automatic close_frame();
        logic [31:0] c, dummy;
        emit_be32({adl_hi[15:0], adl_lo[15:0]}, idat_crc);
        emit_be32(idat_crc ^ upng_pkg::AllOnes, dummy);
        emit_be32(32'd0, dummy);
        c = upng_pkg::AllOnes;
        emit_be32(32'h49454E44, c);
        emit_be32(c ^ upng_pkg::AllOnes, dummy);
        col_pos = 0;
        blk_fill = 0;
        raw_left = 0;
        adl_lo = 1;
        adl_hi = 0;
        idat_crc = upng_pkg::AllOnes;
    endtask

    // file words caused by one pixel
    task automatic predict_pixel(input logic [23:0] px);
        logic       ended;
        file_word_t w;
        int         n;
        ended = 1'b0;
        pending_bytes.delete();
        if (raw_left == 0)
            open_frame();
        if (col_pos == 0)
            emit_raw(8'h00);
        emit_raw(px[7:0]);
        emit_raw(px[15:8]);
        emit_raw(px[23:16]);
        col_pos++;
        if (col_pos >= frm_w)
            col_pos = 0;
        if (raw_left == 0)
        begin
            close_frame();
            ended = 1'b1;
        end
        n = (pending_bytes.size() + 3) / 4;
        for (int k = 0; k < n; k++)
        begin
            w = '0;
            for (int j = 0; j < 4; j++)
            begin
                if (pending_bytes.size() > 0)
                begin
                    w.data[31 - 8 * j -: 8] = pending_bytes.pop_front();
                    w.nbytes++;
                end
            end
            w.last = (k + 1 == n);
            w.fend = ended && (k + 1 == n);
            file_words_due.push_back(w);
        end
    endtask

    // pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pixel_queue.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: predict on accepted pixels and config writes, check file words
    always @(posedge clk)
    begin
        file_word_t e;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == upng_pkg::CfgWidth)
                    size_w_reg = cfg_data;
                else if (cfg_index == upng_pkg::CfgHeight)
                    size_h_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
                predict_pixel(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (file_words_due.size() == 0)
                begin
                    $error("unexpected file word %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    e = file_words_due.pop_front();
                    if (m_tdata[31:0] !== e.data)
                    begin
                        $error("out_data expected %h actual %h", e.data, m_tdata[31:0]);
                        error_count++;
                    end
                    if (m_tdata[34:32] !== e.nbytes)
                    begin
                        $error("byte_count expected %0d actual %0d", e.nbytes, m_tdata[34:32]);
                        error_count++;
                    end
                    if (m_tlast !== e.last)
                    begin
                        $error("run_last expected %b actual %b", e.last, m_tlast);
                        error_count++;
                    end
                    if (m_tuser !== e.fend)
                    begin
                        $error("frame_end expected %b actual %b", e.fend, m_tuser);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("tb_uncompressed_png_stream_encoder: done, errors");
            $finish;
        end
    end

    task automatic reg_write(input logic [7:0] idx, input logic [14:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (!(pixel_queue.size() == 0 && !s_tvalid && file_words_due.size() == 0))
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            pixel_queue.push_back(24'($urandom()));
    endtask

    // a handful of complete frames of random small size
    task automatic random_frames(input int pixel_budget);
        int w, h, sent;
        sent = 0;
        while (sent < pixel_budget)
        begin
            w = $urandom_range(1, 9);
            h = $urandom_range(1, 4);
            drain();
            reg_write(upng_pkg::CfgWidth, 15'(w));
            reg_write(upng_pkg::CfgHeight, 15'(h));
            push_random(w * h);
            sent += w * h;
        end
    endtask

    initial
    begin
        size_w_reg = 15'd1;
        size_h_reg = 15'd1;
        frm_w = 1;
        frm_h = 1;
        col_pos = 0;
        blk_fill = 0;
        raw_left = 0;
        adl_lo = 1;
        adl_hi = 0;
        idat_crc = upng_pkg::AllOnes;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 36;
        recv_idle_pct = 58;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset sizes, all-zero and all-ones pixels
        pixel_queue.push_back(24'h000000);
        pixel_queue.push_back(24'hFFFFFF);
        drain();
        // zero sizes act as one; writes to unused indexes change nothing
        reg_write(upng_pkg::CfgWidth, 15'd0);
        reg_write(upng_pkg::CfgHeight, 15'd0);
        reg_write(CfgSpare, 15'h7FFF);
        reg_write(CfgTop, 15'h1234);
        pixel_queue.push_back(24'h5AA5C3);
        drain();
        // first five pixels of a 3x2 frame of extreme samples
        reg_write(upng_pkg::CfgWidth, 15'd3);
        reg_write(upng_pkg::CfgHeight, 15'd2);
        pixel_queue.push_back(24'hFF0000);
        pixel_queue.push_back(24'h00FF00);
        pixel_queue.push_back(24'h0000FF);
        pixel_queue.push_back(24'h808080);
        pixel_queue.push_back(24'h7F7F7F);
        drain();
        // size change mid-frame applies to the next frame only
        reg_write(upng_pkg::CfgWidth, 15'd2);
        reg_write(upng_pkg::CfgHeight, 15'd3);
        pixel_queue.push_back(24'h010203);
        push_random(6);

        random_frames(80);
        drain();
        send_idle_pct = 58;
        recv_idle_pct = 36;
        random_frames(90);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        reg_write(upng_pkg::CfgWidth, 15'd4);
        reg_write(upng_pkg::CfgHeight, 15'd2);
        push_random(8);
        drain();
        // oversize sizes clamp to the maximum: multi-block header, frame left open
        reg_write(upng_pkg::CfgWidth, 15'h7FFF);
        reg_write(upng_pkg::CfgHeight, 15'h7FFF);
        push_random(12);
        drain();

        if (error_count == 0)
            $display("tb_uncompressed_png_stream_encoder: done, clean");
        else
            $display("tb_uncompressed_png_stream_encoder: done, errors");
        $finish;
    end

endmodule

// File: files.f
src/upng_pkg.sv
src/uncompressed_png_stream_encoder.sv
src/upng_checker.sv
tb/tb_uncompressed_png_stream_encoder.sv
